[src/hsv2rgb_pkg.sv]
// Shared types, constants and the divide-by-255 helper for the HSV to RGB pipeline.
`default_nettype none

package hsv2rgb_pkg;

  // Brightness width; val_t and PROD_BITS follow from it (range 8..16)
  localparam int VALUE_BITS = 10;
  localparam int HUE_BITS   = 9;
  localparam int SAT_BITS   = 8;
  localparam int FRAC_BITS  = 8;
  localparam int PROD_BITS  = VALUE_BITS + SAT_BITS;
  localparam int SF_BITS    = SAT_BITS + FRAC_BITS;
  // Shifted terms needed by the reciprocal estimate of x / 255
  localparam int DIV_TERMS  = (PROD_BITS - 1) / 8;

  localparam int HUE_FULL   = 360;
  localparam int SECTOR_DEG = 60;
  localparam int LEVEL_MAX  = 255;

  typedef logic [HUE_BITS-1:0]   hue_t;
  typedef logic [SAT_BITS-1:0]   sat_t;
  typedef logic [FRAC_BITS-1:0]  frac_t;
  typedef logic [VALUE_BITS-1:0] val_t;
  typedef logic [PROD_BITS-1:0]  prod_t;
  typedef logic [SF_BITS-1:0]    sf_t;

  // Hue sectors, named after the color span they cover
  typedef enum logic [2:0] {
    SEC_RY = 3'd0,  // red to yellow: r=v g=t b=p
    SEC_YG = 3'd1,  // yellow to green: r=q g=v b=p
    SEC_GC = 3'd2,  // green to cyan: r=p g=v b=t
    SEC_CB = 3'd3,  // cyan to blue: r=p g=q b=v
    SEC_BM = 3'd4,  // blue to magenta: r=t g=p b=v
    SEC_MR = 3'd5   // magenta to red: r=v g=p b=q
  } sector_t;

  // Front stage to core
  typedef struct packed {
    sector_t sector;
    frac_t   frac;
    sat_t    sat;
    val_t    val;
  } front_t;

  // Core to output stage
  typedef struct packed {
    sector_t sector;
    val_t    val;
    val_t    lo;
    prod_t   fall_prod;
    prod_t   rise_prod;
  } core_t;

  // Truncating x / 255: reciprocal series estimate, then one correction step
  function automatic val_t div255(input prod_t x);
    logic [PROD_BITS:0]   acc;
    logic [PROD_BITS-8:0] q;
    logic [PROD_BITS:0]   rem;
    acc = {1'b0, x};
    for (int k = 1; k <= DIV_TERMS; k++) begin
      acc = acc + ({1'b0, x} >> (8 * k));
    end
    q   = acc[PROD_BITS:8];
    rem = {1'b0, x} - {q, 8'b0} + {8'b0, q};
    if (rem >= (PROD_BITS + 1)'(LEVEL_MAX)) begin
      q = q + (PROD_BITS - 7)'(1);
    end
    return val_t'(q);
  endfunction

endpackage

`default_nettype wire

[src/hsv2rgb_front.sv]
// First pipeline stage: hue wrap, sector decode and in-sector position.
`default_nettype none

module hsv2rgb_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                up_valid,
  output logic                     up_ready,
  input  wire hsv2rgb_pkg::hue_t   up_hue,
  input  wire hsv2rgb_pkg::sat_t   up_sat,
  input  wire hsv2rgb_pkg::val_t   up_val,
  output logic                     dn_valid,
  input  wire logic                dn_ready,
  output hsv2rgb_pkg::front_t      dn_data
);
  import hsv2rgb_pkg::*;

  logic    valid_r;
  front_t  data_r;
  front_t  data_nxt;
  hue_t    hue_w;
  hue_t    base;
  hue_t    rem9;
  logic [9:0] frac_x17;
  sector_t sector;

  // Wrap the hue once, find the sector and scale the remainder by 255/60 = 17/4
  always_comb begin
    hue_w = (up_hue >= hue_t'(HUE_FULL)) ? up_hue - hue_t'(HUE_FULL) : up_hue;
    if (hue_w < hue_t'(SECTOR_DEG)) begin
      sector = SEC_RY;
      base   = '0;
    end else if (hue_w < hue_t'(2 * SECTOR_DEG)) begin
      sector = SEC_YG;
      base   = hue_t'(SECTOR_DEG);
    end else if (hue_w < hue_t'(3 * SECTOR_DEG)) begin
      sector = SEC_GC;
      base   = hue_t'(2 * SECTOR_DEG);
    end else if (hue_w < hue_t'(4 * SECTOR_DEG)) begin
      sector = SEC_CB;
      base   = hue_t'(3 * SECTOR_DEG);
    end else if (hue_w < hue_t'(5 * SECTOR_DEG)) begin
      sector = SEC_BM;
      base   = hue_t'(4 * SECTOR_DEG);
    end else begin
      sector = SEC_MR;
      base   = hue_t'(5 * SECTOR_DEG);
    end
    rem9     = hue_w - base;
    frac_x17 = {rem9[5:0], 4'b0} + {4'b0, rem9[5:0]};
    data_nxt.sector = sector;
    data_nxt.frac   = frac_x17[9:2];
    data_nxt.sat    = up_sat;
    data_nxt.val    = up_val;
  end

  // Advance when the stage is empty or the next stage takes its transaction
  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

`default_nettype wire

[src/hsv2rgb_core.sv]
// Three pipeline stages forming the p level and the q and t products.
`default_nettype none

module hsv2rgb_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                up_valid,
  output logic                     up_ready,
  input  wire hsv2rgb_pkg::front_t up_data,
  output logic                     dn_valid,
  input  wire logic                dn_ready,
  output hsv2rgb_pkg::core_t       dn_data
);
  import hsv2rgb_pkg::*;

  // Stage A: products of saturation and position, and v * (255 - s)
  logic    a_valid_r;
  sector_t a_sector_r;
  val_t    a_val_r;
  sf_t     a_sf_r;
  sf_t     a_sfc_r;
  prod_t   a_lo_prod_r;
  // Stage B: divided by 255
  logic    b_valid_r;
  sector_t b_sector_r;
  val_t    b_val_r;
  frac_t   b_fall_r;
  frac_t   b_rise_r;
  val_t    b_lo_r;
  // Stage C: value times the complemented attenuations
  logic    c_valid_r;
  core_t   c_data_r;

  logic a_ready;
  logic b_ready;
  logic c_ready;
  val_t fall_q;
  val_t rise_q;
  // 255 minus each 8-bit operand, kept at 8 bits before widening
  frac_t frac_c;
  sat_t  sat_c;
  frac_t fall_c;
  frac_t rise_c;

  assign c_ready  = !c_valid_r || dn_ready;
  assign b_ready  = !b_valid_r || c_ready;
  assign a_ready  = !a_valid_r || b_ready;
  assign up_ready = a_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_r <= up_valid;
      end
      if (b_ready) begin
        b_valid_r <= a_valid_r;
      end
      if (c_ready) begin
        c_valid_r <= b_valid_r;
      end
    end
  end

  assign frac_c = ~up_data.frac;
  assign sat_c  = ~up_data.sat;

  // Multiply: s*f, s*(255-f), v*(255-s)
  always_ff @(posedge clk) begin
    if (a_ready && up_valid) begin
      a_sector_r  <= up_data.sector;
      a_val_r     <= up_data.val;
      a_sf_r      <= sf_t'(up_data.sat) * sf_t'(up_data.frac);
      a_sfc_r     <= sf_t'(up_data.sat) * sf_t'(frac_c);
      a_lo_prod_r <= prod_t'(up_data.val) * prod_t'(sat_c);
    end
  end

  // Divide the three products by 255
  assign fall_q = div255(prod_t'(a_sf_r));
  assign rise_q = div255(prod_t'(a_sfc_r));

  always_ff @(posedge clk) begin
    if (b_ready && a_valid_r) begin
      b_sector_r <= a_sector_r;
      b_val_r    <= a_val_r;
      b_fall_r   <= fall_q[FRAC_BITS-1:0];
      b_rise_r   <= rise_q[FRAC_BITS-1:0];
      b_lo_r     <= div255(a_lo_prod_r);
    end
  end

  assign fall_c = ~b_fall_r;
  assign rise_c = ~b_rise_r;

  // Multiply value by 255 minus each attenuation
  always_ff @(posedge clk) begin
    if (c_ready && b_valid_r) begin
      c_data_r.sector    <= b_sector_r;
      c_data_r.val       <= b_val_r;
      c_data_r.lo        <= b_lo_r;
      c_data_r.fall_prod <= prod_t'(b_val_r) * prod_t'(fall_c);
      c_data_r.rise_prod <= prod_t'(b_val_r) * prod_t'(rise_c);
    end
  end

  assign dn_valid = c_valid_r;
  assign dn_data  = c_data_r;

endmodule

`default_nettype wire

[src/hsv2rgb_mix.sv]
// Output stage: final divisions and sector-ordered channel select.
`default_nettype none

module hsv2rgb_mix (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               up_valid,
  output logic                    up_ready,
  input  wire hsv2rgb_pkg::core_t up_data,
  output logic                    dn_valid,
  input  wire logic               dn_ready,
  output hsv2rgb_pkg::val_t       dn_red,
  output hsv2rgb_pkg::val_t       dn_green,
  output hsv2rgb_pkg::val_t       dn_blue
);
  import hsv2rgb_pkg::*;

  logic valid_r;
  val_t red_r;
  val_t green_r;
  val_t blue_r;
  val_t red_nxt;
  val_t green_nxt;
  val_t blue_nxt;
  val_t fall;
  val_t rise;

  // Order v, p, q, t by sector
  always_comb begin
    fall = div255(up_data.fall_prod);
    rise = div255(up_data.rise_prod);
    case (up_data.sector)
      SEC_RY: begin
        red_nxt = up_data.val; green_nxt = rise;        blue_nxt = up_data.lo;
      end
      SEC_YG: begin
        red_nxt = fall;        green_nxt = up_data.val; blue_nxt = up_data.lo;
      end
      SEC_GC: begin
        red_nxt = up_data.lo;  green_nxt = up_data.val; blue_nxt = rise;
      end
      SEC_CB: begin
        red_nxt = up_data.lo;  green_nxt = fall;        blue_nxt = up_data.val;
      end
      SEC_BM: begin
        red_nxt = rise;        green_nxt = up_data.lo;  blue_nxt = up_data.val;
      end
      default: begin
        red_nxt = up_data.val; green_nxt = up_data.lo;  blue_nxt = fall;
      end
    endcase
  end

  // Output register doubles as the skid stage
  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_red   = red_r;
  assign dn_green = green_r;
  assign dn_blue  = blue_r;

endmodule

`default_nettype wire

[src/hsv_to_rgb_converter.sv]
// Top level of the integer six-sector HSV to RGB pixel pipeline.
//
//   Channel  Direction  Handshake              Payload
//   in_      input      in_valid / in_ready    in_hue, in_saturation, in_value
//   out_     output     out_valid / out_ready  out_red, out_green, out_blue
//
// Five register stages (front, core A, B, C, mix), each holding a valid bit with its data.
// One pixel per clock is sustained while out_ready is high.
// The output register frees as soon as out_ready is high, so a full pipe keeps flowing.
// A stall backs up stage by stage; empty stages still fill, nothing is dropped or doubled.
// Synchronous active-low reset clears the valid bits only.
`default_nettype none

module hsv_to_rgb_converter (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire hsv2rgb_pkg::hue_t in_hue,
  input  wire hsv2rgb_pkg::sat_t in_saturation,
  input  wire hsv2rgb_pkg::val_t in_value,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output hsv2rgb_pkg::val_t      out_red,
  output hsv2rgb_pkg::val_t      out_green,
  output hsv2rgb_pkg::val_t      out_blue
);
  import hsv2rgb_pkg::*;

  logic   front_valid;
  logic   front_ready;
  front_t front_data;
  logic   core_valid;
  logic   core_ready;
  core_t  core_data;

  // Sector and position
  hsv2rgb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_hue   (in_hue),
    .up_sat   (in_saturation),
    .up_val   (in_value),
    .dn_valid (front_valid),
    .dn_ready (front_ready),
    .dn_data  (front_data)
  );

  // Levels p, and products for q and t
  hsv2rgb_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (front_valid),
    .up_ready (front_ready),
    .up_data  (front_data),
    .dn_valid (core_valid),
    .dn_ready (core_ready),
    .dn_data  (core_data)
  );

  // Channel select and output register
  hsv2rgb_mix u_mix (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (core_valid),
    .up_ready (core_ready),
    .up_data  (core_data),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_red   (out_red),
    .dn_green (out_green),
    .dn_blue  (out_blue)
  );

endmodule

`default_nettype wire

[src/hsv2rgb_checker.sv]
// Port-level checks for the HSV to RGB pipeline, bound to the top level.
`default_nettype none

module hsv2rgb_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire hsv2rgb_pkg::val_t out_red,
  input wire hsv2rgb_pkg::val_t out_green,
  input wire hsv2rgb_pkg::val_t out_blue
);
  import hsv2rgb_pkg::*;

  // Hold a stalled result transaction unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_red) && $stable(out_green)
      && $stable(out_blue))
    else $error("stalled result changed or dropped");

  // A free output stage means every stage can advance, so input is open
  a_ready_open: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ready || !out_valid) |-> in_ready)
    else $error("input blocked while output stage can move");

  // Reset empties the pipe
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // With the output stage empty and the input stalled, no result may appear
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!out_valid) && $past(!in_ready) |-> !out_valid)
    else $error("input stalled with an empty output stage");

endmodule

bind hsv_to_rgb_converter hsv2rgb_checker u_hsv2rgb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_red   (out_red),
  .out_green (out_green),
  .out_blue  (out_blue)
);

`default_nettype wire

[tb/tb_hsv_to_rgb_converter.sv]
// Self-checking testbench for the HSV to RGB pixel pipeline with random handshake idling.
`default_nettype none

module tb_hsv_to_rgb_converter;
  timeunit 1ns;
  timeprecision 1ps;

  import hsv2rgb_pkg::*;

  localparam int N_RANDOM   = 950;
  localparam int IDLE_LIMIT = 1000;
  localparam int DRAIN_CYC  = 10;

  typedef struct {
    hue_t hue;
    sat_t sat;
    val_t val;
  } pixel_t;

  typedef struct {
    val_t red;
    val_t green;
    val_t blue;
  } rgb_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  hue_t in_hue = '0;
  sat_t in_saturation = '0;
  val_t in_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  val_t out_red;
  val_t out_green;
  val_t out_blue;

  pixel_t pixel_q[$];
  rgb_t   rgb_expected_q[$];
  pixel_t next_pixel;
  int     n_pixels = 0;
  int     n_accepted = 0;
  int     n_errors = 0;
  int     idle_cycles = 0;
  logic   in_taken = 1'b0;
  int     burst_left = 0;
  int     gap_left = 0;
  int     stall_mode = 0;
  int     stall_phase = 0;
  logic [7:0] stall_pattern = 8'hff;

  hsv_to_rgb_converter dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_hue       (in_hue),
    .in_saturation(in_saturation),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue)
  );

  always #2 clk = ~clk;

  // Convert one pixel: sector from hue, then the three truncated levels
  function automatic rgb_t hsv_color(input pixel_t px);
    int unsigned deg, pos, v, s, lo, fall, rise;
    sector_t     sec;
    rgb_t        c;
    deg = px.hue;
    v   = px.val;
    s   = px.sat;
    if (deg >= HUE_FULL) begin
      deg = deg - HUE_FULL;
    end
    sec  = sector_t'(deg / SECTOR_DEG);
    pos  = (deg % SECTOR_DEG) * LEVEL_MAX / SECTOR_DEG;
    lo   = v * (LEVEL_MAX - s) / LEVEL_MAX;
    fall = v * (LEVEL_MAX - s * pos / LEVEL_MAX) / LEVEL_MAX;
    rise = v * (LEVEL_MAX - s * (LEVEL_MAX - pos) / LEVEL_MAX) / LEVEL_MAX;
    case (sec)
      SEC_RY: begin c.red = val_t'(v);    c.green = val_t'(rise); c.blue = val_t'(lo);   end
      SEC_YG: begin c.red = val_t'(fall); c.green = val_t'(v);    c.blue = val_t'(lo);   end
      SEC_GC: begin c.red = val_t'(lo);   c.green = val_t'(v);    c.blue = val_t'(rise); end
      SEC_CB: begin c.red = val_t'(lo);   c.green = val_t'(fall); c.blue = val_t'(v);    end
      SEC_BM: begin c.red = val_t'(rise); c.green = val_t'(lo);   c.blue = val_t'(v);    end
      default: begin c.red = val_t'(v);   c.green = val_t'(lo);   c.blue = val_t'(fall); end
    endcase
    return c;
  endfunction

  function automatic void add_pixel(input int h, input int s, input int v);
    pixel_t px;
    px.hue = hue_t'(h);
    px.sat = sat_t'(s);
    px.val = val_t'(v);
    pixel_q.push_back(px);
    n_pixels++;
  endfunction

  // Bias toward sector edges, the wrap region and the saturation/value extremes
  function automatic void add_random_pixel();
    int h, s, v, pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      h = $urandom_range(0, (1 << HUE_BITS) - 1);
    end else if (pick == 1) begin
      h = $urandom_range(0, 6) * SECTOR_DEG + $urandom_range(0, 2) - 1;
      if (h < 0) h = 0;
    end else begin
      h = $urandom_range(0, HUE_FULL);
    end
    pick = $urandom_range(0, 9);
    s = (pick == 0) ? 0 : (pick == 1) ? LEVEL_MAX : $urandom_range(0, LEVEL_MAX);
    pick = $urandom_range(0, 9);
    v = (pick == 0) ? 0 : (pick == 1) ? (1 << VALUE_BITS) - 1
                                      : $urandom_range(0, (1 << VALUE_BITS) - 1);
    add_pixel(h, s, v);
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    n_errors++;
  endtask

  // Stimulus, reset and end of run
  initial begin
    // sector edges, hue wrap, grey, black and full-scale corners
    add_pixel(0, 255, 1023);
    add_pixel(59, 255, 1023);
    add_pixel(60, 255, 1023);
    add_pixel(119, 200, 1023);
    add_pixel(120, 255, 512);
    add_pixel(179, 255, 1023);
    add_pixel(180, 128, 1023);
    add_pixel(239, 255, 700);
    add_pixel(240, 255, 1023);
    add_pixel(299, 255, 1023);
    add_pixel(300, 77, 1023);
    add_pixel(359, 255, 1023);
    add_pixel(360, 255, 1023);
    add_pixel(361, 255, 1023);
    add_pixel(400, 180, 900);
    add_pixel(511, 255, 1023);
    add_pixel(30, 0, 1023);
    add_pixel(200, 0, 345);
    add_pixel(90, 255, 0);
    add_pixel(0, 0, 0);
    add_pixel(45, 1, 1);
    add_pixel(330, 254, 1022);
    add_pixel(150, 255, 1);
    add_pixel(270, 128, 256);
    for (int i = 0; i < N_RANDOM; i++) begin
      add_random_pixel();
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (n_accepted != n_pixels) @(posedge clk);
    while (rgb_expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Drive pixels in bursts with random gaps; hold a transaction until it is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      in_valid <= 1'b1;
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      in_valid <= 1'b0;
    end else if (pixel_q.size() > 0) begin
      next_pixel = pixel_q.pop_front();
      in_hue <= next_pixel.hue;
      in_saturation <= next_pixel.sat;
      in_value <= next_pixel.val;
      in_valid <= 1'b1;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 24);
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver back-pressure: switch between stall styles at random intervals
  always @(negedge clk) begin
    if (stall_phase == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_pattern <= 8'($urandom_range(1, 255));
      stall_phase <= $urandom_range(20, 80);
    end else begin
      stall_phase <= stall_phase - 1;
      stall_pattern <= {stall_pattern[6:0], stall_pattern[7]};
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= stall_pattern[0];
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Check results against the oldest expectation, then record new transactions
  always @(posedge clk) begin
    rgb_t want;
    in_taken <= in_valid && in_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (rgb_expected_q.size() == 0) begin
          report_error($sformatf("unexpected result r=%0d g=%0d b=%0d",
                                 out_red, out_green, out_blue));
        end else begin
          want = rgb_expected_q.pop_front();
          if (out_red !== want.red)
            report_error($sformatf("red got %0d want %0d", out_red, want.red));
          if (out_green !== want.green)
            report_error($sformatf("green got %0d want %0d", out_green, want.green));
          if (out_blue !== want.blue)
            report_error($sformatf("blue got %0d want %0d", out_blue, want.blue));
        end
      end
      if (in_valid && in_ready) begin
        rgb_expected_q.push_back(hsv_color('{in_hue, in_saturation, in_value}));
        n_accepted <= n_accepted + 1;
      end
    end
  end

  // Watchdog: end the run if no transaction moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule

`default_nettype wire
